FILE: sv/nm3_pkg.sv
package nm3_pkg;

    localparam int unsigned W         = 32;   // Q16.16 word
    localparam int unsigned PROD_W    = 64;   // product of two words
    localparam int unsigned ADJ_W     = 65;   // signed adjugate entry
    localparam int unsigned AMAG_W    = 64;   // adjugate magnitude
    localparam int unsigned DET_W     = 97;   // signed determinant
    localparam int unsigned DMAG_W    = 96;   // determinant magnitude
    localparam int unsigned DIV_STEPS = 32;   // quotient bits, one per stage
    localparam int unsigned N_ENT     = 9;

    // Divisor used when the determinant is zero: dividing |A|<<32 by 2^48
    // gives |A|>>16, the unscaled adjugate in Q16.16.
    localparam logic [DMAG_W-1:0] DEN_UNIT = 96'h1 << 48;

    localparam logic [W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [W-1:0] SAT_NEG = 32'h8000_0000;

    // adj[k] = m[A]*m[B] - m[C]*m[D], m indexed row*3+col
    localparam int unsigned COF_A [N_ENT] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int unsigned COF_B [N_ENT] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int unsigned COF_C [N_ENT] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int unsigned COF_D [N_ENT] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic [AMAG_W-1:0] a_mag;
        logic [DMAG_W-1:0] den;
        logic              neg;
        logic              sat;   // quotient is 2^32 or more
    } t_lane;

    function automatic logic [W-1:0] sat_q(input logic neg, input logic sat,
                                           input logic [W-1:0] q);
        logic [W-1:0] res;
        if (sat) begin
            res = neg ? SAT_NEG : SAT_POS;
        end else if (!neg) begin
            res = q[W-1] ? SAT_POS : q;
        end else if (q > SAT_NEG) begin
            res = SAT_NEG;
        end else begin
            res = ~q + 32'd1;
        end
        return res;
    endfunction

endpackage

FILE: sv/nm3_front.sv
// Adjugate, determinant and divider operand setup: six register stages.
module nm3_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [nm3_pkg::W-1:0]      i_m [nm3_pkg::N_ENT],
    output logic                              o_valid,
    output logic                              o_inv,
    output nm3_pkg::t_lane                    o_lane [nm3_pkg::N_ENT]
);

    logic [5:0] r_v;

    // stage 1: cofactor products
    logic signed [nm3_pkg::PROD_W-1:0] r_p1 [nm3_pkg::N_ENT];
    logic signed [nm3_pkg::PROD_W-1:0] r_p2 [nm3_pkg::N_ENT];
    logic signed [nm3_pkg::W-1:0]      r_c0_1 [3];
    // stage 2: adjugate
    logic signed [nm3_pkg::ADJ_W-1:0]  r_adj2 [nm3_pkg::N_ENT];
    logic signed [nm3_pkg::W-1:0]      r_c0_2 [3];
    // stage 3: determinant partial products
    logic signed [65:0]                r_lo [3];
    logic signed [65:0]                r_hi [3];
    logic signed [nm3_pkg::ADJ_W-1:0]  r_adj3 [nm3_pkg::N_ENT];
    // stage 4: determinant terms
    logic signed [nm3_pkg::DET_W-1:0]  r_term [3];
    logic signed [nm3_pkg::ADJ_W-1:0]  r_adj4 [nm3_pkg::N_ENT];
    // stage 5: determinant, adjugate magnitudes
    logic signed [nm3_pkg::DET_W-1:0]  r_det;
    logic [nm3_pkg::AMAG_W-1:0]        r_amag5 [nm3_pkg::N_ENT];
    logic                              r_aneg5 [nm3_pkg::N_ENT];
    // stage 6: divider operands
    nm3_pkg::t_lane                    r_lane [nm3_pkg::N_ENT];
    logic                              r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
                r_p1[k] <= i_m[nm3_pkg::COF_A[k]] * i_m[nm3_pkg::COF_B[k]];
                r_p2[k] <= i_m[nm3_pkg::COF_C[k]] * i_m[nm3_pkg::COF_D[k]];
            end
            r_c0_1[0] <= i_m[0];
            r_c0_1[1] <= i_m[3];
            r_c0_1[2] <= i_m[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
                r_adj2[k] <= $signed({r_p1[k][63], r_p1[k]}) - $signed({r_p2[k][63], r_p2[k]});
            end
            r_c0_2 <= r_c0_1;
        end
    end

    // m[k][0] * adj[0][k], adjugate split into signed high and unsigned low halves
    logic signed [32:0] c0_33 [3];
    logic signed [32:0] lo_33 [3];
    logic signed [32:0] hi_33 [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c0_33[k] = {r_c0_2[k][31], r_c0_2[k]};
            lo_33[k] = {1'b0, r_adj2[k][31:0]};
            hi_33[k] = r_adj2[k][64:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= c0_33[k] * lo_33[k];
                r_hi[k] <= c0_33[k] * hi_33[k];
            end
            r_adj3 <= r_adj2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_term[k] <= $signed({r_hi[k][64:0], 32'b0})
                           + $signed({{32{r_lo[k][64]}}, r_lo[k][64:0]});
            end
            r_adj4 <= r_adj3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= r_term[0] + r_term[1] + r_term[2];
            for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
                r_aneg5[k] <= r_adj4[k][64];
                r_amag5[k] <= r_adj4[k][64] ? 64'(-r_adj4[k]) : r_adj4[k][63:0];
            end
        end
    end

    logic                       det_neg;
    logic                       det_nz;
    logic [nm3_pkg::DET_W-1:0]  det_abs;
    logic [nm3_pkg::DMAG_W-1:0] den;
    always_comb begin
        det_neg = r_det[96];
        det_nz  = (r_det != '0);
        det_abs = det_neg ? 97'(-r_det) : 97'(r_det);
        den     = det_nz ? det_abs[95:0] : nm3_pkg::DEN_UNIT;
    end

    // output k is normal entry (row k/3, col k%3) = adjugate (k%3, k/3)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inv <= det_nz;
            for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
                r_lane[k].a_mag <= r_amag5[(k % 3) * 3 + k / 3];
                r_lane[k].den   <= den;
                r_lane[k].neg   <= r_aneg5[(k % 3) * 3 + k / 3] ^ (det_nz & det_neg);
                r_lane[k].sat   <= ({32'b0, r_amag5[(k % 3) * 3 + k / 3]} >= den);
            end
        end
    end

    assign o_valid = r_v[5];
    assign o_inv   = r_inv;
    assign o_lane  = r_lane;

endmodule

FILE: sv/nm3_div.sv
// Restoring divider, one quotient bit per stage. The numerator is |A|<<32,
// so the remainder starts at |A| and only zeros are shifted in.
module nm3_div (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  nm3_pkg::t_lane       i_lane,
    output logic [nm3_pkg::W-1:0] o_res
);

    logic [nm3_pkg::DMAG_W-1:0] r_rem [nm3_pkg::DIV_STEPS];
    logic [nm3_pkg::DMAG_W-1:0] r_den [nm3_pkg::DIV_STEPS];
    logic [nm3_pkg::W-1:0]      r_q   [nm3_pkg::DIV_STEPS];
    logic                       r_neg [nm3_pkg::DIV_STEPS];
    logic                       r_sat [nm3_pkg::DIV_STEPS];

    for (genvar s = 0; s < nm3_pkg::DIV_STEPS; s++) begin : g_step
        logic [nm3_pkg::DMAG_W-1:0] rem_in;
        logic [nm3_pkg::DMAG_W-1:0] den_in;
        logic [nm3_pkg::W-1:0]      q_in;
        logic                       neg_in;
        logic                       sat_in;
        logic [nm3_pkg::DMAG_W:0]   sh;
        logic                       ge;
        logic [nm3_pkg::DMAG_W:0]   diff;

        if (s == 0) begin : g_first
            assign rem_in = {32'b0, i_lane.a_mag};
            assign den_in = i_lane.den;
            assign q_in   = '0;
            assign neg_in = i_lane.neg;
            assign sat_in = i_lane.sat;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign q_in   = r_q[s-1];
            assign neg_in = r_neg[s-1];
            assign sat_in = r_sat[s-1];
        end

        assign sh   = {rem_in, 1'b0};
        assign diff = sh - {1'b0, den_in};
        assign ge   = (sh >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? diff[nm3_pkg::DMAG_W-1:0] : sh[nm3_pkg::DMAG_W-1:0];
                r_den[s] <= den_in;
                r_q[s]   <= {q_in[nm3_pkg::W-2:0], ge};
                r_neg[s] <= neg_in;
                r_sat[s] <= sat_in;
            end
        end
    end

    assign o_res = nm3_pkg::sat_q(r_neg[nm3_pkg::DIV_STEPS-1], r_sat[nm3_pkg::DIV_STEPS-1],
                                  r_q[nm3_pkg::DIV_STEPS-1]);

endmodule

FILE: sv/normal_matrix_3x3.sv
// Normal matrix (inverse transpose) of a 3x3 Q16.16 matrix. Fully pipelined:
// one matrix per clock unless stalled, through 6 stages for adjugate and
// determinant, 32 divider stages at one quotient bit each and one output
// stage. The pipeline advances as a whole whenever the output register is
// empty or being taken, so o_stall follows i_stall only while a result is
// held. A zero determinant gives the adjugate scaled to Q16.16 with
// o_invertible low; all entries saturate to the Q16.16 range.
module normal_matrix_3x3 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_in_r0c0,
    input  logic [31:0] i_in_r0c1,
    input  logic [31:0] i_in_r0c2,
    input  logic [31:0] i_in_r1c0,
    input  logic [31:0] i_in_r1c1,
    input  logic [31:0] i_in_r1c2,
    input  logic [31:0] i_in_r2c0,
    input  logic [31:0] i_in_r2c1,
    input  logic [31:0] i_in_r2c2,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_nrm_r0c0,
    output logic [31:0] o_nrm_r0c1,
    output logic [31:0] o_nrm_r0c2,
    output logic [31:0] o_nrm_r1c0,
    output logic [31:0] o_nrm_r1c1,
    output logic [31:0] o_nrm_r1c2,
    output logic [31:0] o_nrm_r2c0,
    output logic [31:0] o_nrm_r2c1,
    output logic [31:0] o_nrm_r2c2,
    output logic        o_invertible
);

    logic                           en;
    logic signed [nm3_pkg::W-1:0]   m [nm3_pkg::N_ENT];
    logic                           front_v;
    logic                           front_inv;
    nm3_pkg::t_lane                 lane [nm3_pkg::N_ENT];
    logic [nm3_pkg::W-1:0]          res [nm3_pkg::N_ENT];

    logic [nm3_pkg::DIV_STEPS-1:0]  r_dv;
    logic [nm3_pkg::DIV_STEPS-1:0]  r_dinv;
    logic                           r_out_v;
    logic                           r_out_inv;
    logic [nm3_pkg::W-1:0]          r_out [nm3_pkg::N_ENT];

    assign en      = !r_out_v || !i_stall;
    assign o_stall = !en;

    assign m[0] = i_in_r0c0;
    assign m[1] = i_in_r0c1;
    assign m[2] = i_in_r0c2;
    assign m[3] = i_in_r1c0;
    assign m[4] = i_in_r1c1;
    assign m[5] = i_in_r1c2;
    assign m[6] = i_in_r2c0;
    assign m[7] = i_in_r2c1;
    assign m[8] = i_in_r2c2;

    nm3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_m     (m),
        .o_valid (front_v),
        .o_inv   (front_inv),
        .o_lane  (lane)
    );

    for (genvar k = 0; k < nm3_pkg::N_ENT; k++) begin : g_lane
        nm3_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (lane[k]),
            .o_res  (res[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv    <= '0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_dv    <= {r_dv[nm3_pkg::DIV_STEPS-2:0], front_v};
            r_out_v <= r_dv[nm3_pkg::DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dinv    <= {r_dinv[nm3_pkg::DIV_STEPS-2:0], front_inv};
            r_out_inv <= r_dinv[nm3_pkg::DIV_STEPS-1];
            r_out     <= res;
        end
    end

    assign o_valid      = r_out_v;
    assign o_invertible = r_out_inv;
    assign o_nrm_r0c0   = r_out[0];
    assign o_nrm_r0c1   = r_out[1];
    assign o_nrm_r0c2   = r_out[2];
    assign o_nrm_r1c0   = r_out[3];
    assign o_nrm_r1c1   = r_out[4];
    assign o_nrm_r1c2   = r_out[5];
    assign o_nrm_r2c0   = r_out[6];
    assign o_nrm_r2c1   = r_out[7];
    assign o_nrm_r2c2   = r_out[8];

endmodule

FILE: tb/sv/normal_matrix_3x3_test.sv
`timescale 1ns / 100ps

module normal_matrix_3x3_test;

    localparam int CYCLE_LIMIT = 300000;
    localparam int N_RAND_HALF = 900;

    typedef struct {
        logic [nm3_pkg::W-1:0] v [nm3_pkg::N_ENT];
    } t_matrix;

    typedef struct {
        logic [nm3_pkg::W-1:0] e [nm3_pkg::N_ENT];
        logic                  inv;
    } t_normal;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [nm3_pkg::W-1:0] in_w [nm3_pkg::N_ENT];
    logic                  o_valid;
    logic                  i_stall;
    logic [nm3_pkg::W-1:0] got [nm3_pkg::N_ENT];
    logic                  o_invertible;

    t_matrix pending_mats [$];
    t_normal expected_normals [$];
    t_matrix cur_mat;
    int      burst_left;
    int      gap_left;
    int      cycle_cnt = 0;
    int      mismatch_cnt = 0;

    normal_matrix_3x3 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_r0c0   (in_w[0]),
        .i_in_r0c1   (in_w[1]),
        .i_in_r0c2   (in_w[2]),
        .i_in_r1c0   (in_w[3]),
        .i_in_r1c1   (in_w[4]),
        .i_in_r1c2   (in_w[5]),
        .i_in_r2c0   (in_w[6]),
        .i_in_r2c1   (in_w[7]),
        .i_in_r2c2   (in_w[8]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_nrm_r0c0  (got[0]),
        .o_nrm_r0c1  (got[1]),
        .o_nrm_r0c2  (got[2]),
        .o_nrm_r1c0  (got[3]),
        .o_nrm_r1c1  (got[4]),
        .o_nrm_r1c2  (got[5]),
        .o_nrm_r2c0  (got[6]),
        .o_nrm_r2c1  (got[7]),
        .o_nrm_r2c2  (got[8]),
        .o_invertible(o_invertible)
    );

    always #6 i_clk = ~i_clk;

    // Exact adjugate / determinant in 128-bit signed, then transpose and saturate.
    function automatic t_normal normal_of(t_matrix mt);
        logic signed [127:0]   m [nm3_pkg::N_ENT];
        logic signed [127:0]   adj [nm3_pkg::N_ENT];
        logic signed [127:0]   det;
        logic [127:0]          dmag;
        logic [127:0]          amag;
        logic [127:0]          q;
        logic                  neg;
        logic [nm3_pkg::W-1:0] word;
        t_normal               res;
        for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
            m[k] = $signed(mt.v[k]);
        end
        adj[0] = m[4] * m[8] - m[5] * m[7];
        adj[1] = m[2] * m[7] - m[1] * m[8];
        adj[2] = m[1] * m[5] - m[2] * m[4];
        adj[3] = m[5] * m[6] - m[3] * m[8];
        adj[4] = m[0] * m[8] - m[2] * m[6];
        adj[5] = m[2] * m[3] - m[0] * m[5];
        adj[6] = m[3] * m[7] - m[4] * m[6];
        adj[7] = m[1] * m[6] - m[0] * m[7];
        adj[8] = m[0] * m[4] - m[1] * m[3];
        det = m[0] * adj[0] + m[3] * adj[1] + m[6] * adj[2];
        dmag = (det < 0) ? -det : det;
        res.inv = (det != 0);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                amag = (adj[r*3+c] < 0) ? -adj[r*3+c] : adj[r*3+c];
                if (res.inv) begin
                    q   = (amag << 32) / dmag;
                    neg = (adj[r*3+c] < 0) ^ (det < 0);
                end else begin
                    q   = amag >> 16;
                    neg = (adj[r*3+c] < 0);
                end
                if (q == 0) neg = 1'b0;
                if (!neg) begin
                    word = (q > 128'h7FFF_FFFF) ? nm3_pkg::SAT_POS : q[nm3_pkg::W-1:0];
                end else begin
                    word = (q > 128'h8000_0000) ? nm3_pkg::SAT_NEG
                                                : (~q[nm3_pkg::W-1:0] + 32'd1);
                end
                res.e[c*3+r] = word;
            end
        end
        return res;
    endfunction

    function automatic logic [nm3_pkg::W-1:0] rand_word(int kind);
        logic [nm3_pkg::W-1:0] w;
        case (kind)
            0: w = $urandom;
            1: w = $urandom_range(0, 32'h3FFFF);
            2: w = $urandom_range(0, 15);
            default: begin
                case ($urandom_range(0, 5))
                    0: w = 32'h0;
                    1: w = 32'h1;
                    2: w = nm3_pkg::SAT_POS;
                    3: w = nm3_pkg::SAT_NEG;
                    4: w = 32'hFFFF_FFFF;
                    default: w = 32'h0001_0000;
                endcase
            end
        endcase
        if (kind != 0 && kind != 3 && $urandom_range(0, 1)) w = -w;
        return w;
    endfunction

    function automatic t_matrix rand_matrix();
        t_matrix mt;
        int      shape;
        int      kind;
        shape = $urandom_range(0, 99);
        kind  = $urandom_range(0, 2);
        for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
            mt.v[k] = (shape < 30) ? rand_word($urandom_range(0, 3)) : rand_word(kind);
        end
        if (shape >= 60 && shape < 75) begin
            // singular: one row repeats another
            int src;
            int dst;
            src = $urandom_range(0, 2);
            dst = (src + $urandom_range(1, 2)) % 3;
            for (int c = 0; c < 3; c++) mt.v[dst*3+c] = mt.v[src*3+c];
        end else if (shape >= 75 && shape < 80) begin
            int col;
            col = $urandom_range(0, 2);
            for (int r = 0; r < 3; r++) mt.v[r*3+col] = '0;
        end else if (shape >= 80 && shape < 90) begin
            for (int k = 0; k < nm3_pkg::N_ENT; k++) if (k % 4 != 0) mt.v[k] = '0;
        end
        return mt;
    endfunction

    function automatic t_matrix fill_matrix(logic [nm3_pkg::W-1:0] d,
                                            logic [nm3_pkg::W-1:0] o);
        t_matrix mt;
        for (int k = 0; k < nm3_pkg::N_ENT; k++) mt.v[k] = (k % 4 == 0) ? d : o;
        return mt;
    endfunction

    task automatic queue_mat(t_matrix mt);
        pending_mats.insert(pending_mats.size(), mt);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
            for (int k = 0; k < nm3_pkg::N_ENT; k++) in_w[k] <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_normals.insert(expected_normals.size(), normal_of(cur_mat));
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pending_mats.size() > 0) begin
                    cur_mat = pending_mats.pop_front();
                    for (int k = 0; k < nm3_pkg::N_ENT; k++) in_w[k] <= cur_mat.v[k];
                    i_valid <= 1'b1;
                    if (burst_left <= 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ((cycle_cnt / 3000) % 3 == 0) ? 0 : $urandom_range(0, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_normal want;
        logic    bad;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case ((cycle_cnt / 2000) % 4)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 2) == 0);
                2: i_stall <= ((cycle_cnt % 7) < 3);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
            if (o_valid && !i_stall) begin
                if (expected_normals.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) $display("ERROR: unexpected transaction at cycle %0d",
                                                     cycle_cnt);
                end else begin
                    want = expected_normals.pop_front();
                    bad  = (o_invertible !== want.inv);
                    for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
                        if (got[k] !== want.e[k]) bad = 1'b1;
                    end
                    if (bad) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("ERROR: cycle %0d inv exp %0b got %0b", cycle_cnt,
                                     want.inv, o_invertible);
                            for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
                                $display("  nrm[%0d] exp %08h got %08h", k, want.e[k], got[k]);
                            end
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_mats.size() != 0 || i_valid || expected_normals.size() != 0);
    endtask

    initial begin
        t_matrix mt;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, zero, extremes, scaled diagonals, singular, tiny determinant
        queue_mat(fill_matrix(32'h0001_0000, 32'h0));
        queue_mat(fill_matrix(32'h0, 32'h0));
        queue_mat(fill_matrix(nm3_pkg::SAT_POS, nm3_pkg::SAT_POS));
        queue_mat(fill_matrix(nm3_pkg::SAT_NEG, nm3_pkg::SAT_NEG));
        queue_mat(fill_matrix(nm3_pkg::SAT_POS, 32'h0));
        queue_mat(fill_matrix(nm3_pkg::SAT_NEG, 32'h0));
        queue_mat(fill_matrix(nm3_pkg::SAT_NEG, nm3_pkg::SAT_POS));
        queue_mat(fill_matrix(32'hFFFF_FFFF, 32'h0));
        queue_mat(fill_matrix(32'h1, 32'h0));
        queue_mat(fill_matrix(32'h0002_0000, 32'h0));
        queue_mat(fill_matrix(32'hFFFF_8000, 32'h0));
        queue_mat(fill_matrix(32'h0001_0000, 32'h0000_8000));
        queue_mat(fill_matrix(nm3_pkg::SAT_POS, nm3_pkg::SAT_NEG));
        queue_mat(fill_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        for (int k = 0; k < nm3_pkg::N_ENT; k++) mt.v[k] = (k + 1) << 16;   // rank two
        queue_mat(mt);
        for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
            mt.v[k] = (k % 4 == 0) ? 32'h0001_0000 : 32'h0;
        end
        mt.v[8] = 32'h1;                                           // near singular
        queue_mat(mt);
        for (int k = 0; k < nm3_pkg::N_ENT; k++) mt.v[k] = 32'h5555_AAAA ^ (k * 32'h1111_1111);
        queue_mat(mt);
        for (int k = 0; k < nm3_pkg::N_ENT; k++) begin
            mt.v[k] = ~(32'h5555_AAAA ^ (k * 32'h1111_1111));
        end
        queue_mat(mt);

        for (int n = 0; n < N_RAND_HALF; n++) queue_mat(rand_matrix());
        wait_drained();
        for (int n = 0; n < N_RAND_HALF; n++) queue_mat(rand_matrix());
        wait_drained();
        repeat (60) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/nm3_pkg.sv
sv/nm3_front.sv
sv/nm3_div.sv
sv/normal_matrix_3x3.sv
tb/sv/normal_matrix_3x3_test.sv
